// ===== src/sipq_pkg.sv =====
// ---------------------------------------------------------------------------
// sipq_pkg
// Shared types and codes for the sorted-insert priority queue: transfer
// payloads, operation and status codes, controller/datapath interface.
// ---------------------------------------------------------------------------
package sipq_pkg;

    localparam int VALUE_FIELD_W = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;

    // operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                            func;
        logic signed [VALUE_FIELD_W-1:0] value;
    } sipq_in_t;

    typedef struct packed {
        logic signed [VALUE_FIELD_W-1:0] out_value;
        logic [STATUS_W-1:0]             status;
        logic [COUNT_W-1:0]              count;
        logic                            is_empty;
        logic                            is_full;
    } sipq_out_t;

    // controller -> datapath
    typedef struct packed {
        logic start;    // accept input item, set up the operation
        logic shift;    // one insertion step
        logic dequeue;  // take head data from the store
        logic publish;  // load the output register
    } sipq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_deq;
        logic full;
        logic empty;
        logic shift_stop;
        logic out_free;
    } sipq_sts_t;

endpackage

// ===== src/sipq_ram.sv =====
// ---------------------------------------------------------------------------
// sipq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sipq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sipq_ctrl.sv =====
// ---------------------------------------------------------------------------
// sipq_ctrl
// Controller: sequences accept, insertion walk or head read, and result
// transfer for one item at a time.
// ---------------------------------------------------------------------------
module sipq_ctrl import sipq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sipq_sts_t sts,
    output sipq_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SHIFT  = 4'b0010,
        ST_DEQ    = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start = 1'b1;
                    if (sts.in_deq) begin
                        state_next = sts.empty ? ST_RESULT : ST_DEQ;
                    end else begin
                        state_next = sts.full ? ST_RESULT : ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (sts.shift_stop) begin
                    state_next = ST_RESULT;
                end
            end
            ST_DEQ: begin
                cmd.dequeue = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sipq_dp.sv =====
// ---------------------------------------------------------------------------
// sipq_dp
// Datapath: circular store, head/count registers, insertion index and
// output register.
// ---------------------------------------------------------------------------
module sipq_dp import sipq_pkg::*; #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  sipq_in_t  s_data,
    input  sipq_cmd_t cmd,
    output sipq_sts_t sts,
    output logic      m_valid,
    input  logic      m_ready,
    output sipq_out_t m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0]   val_reg, val_next;
    logic [VALUE_FIELD_W-1:0] pend_value_reg, pend_value_next;
    logic [STATUS_W-1:0]      pend_status_reg, pend_status_next;
    logic                     out_valid_reg, out_valid_next;
    sipq_out_t                out_data_reg, out_data_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0]   ram_wdata, ram_rdata;

    logic [VALUE_WIDTH+VALUE_FIELD_W-1:0] in_ext, rd_ext;
    logic [CW+COUNT_W-1:0]                count_ext;
    logic [VALUE_WIDTH-1:0]               in_val;
    logic [AW:0]                          tail_sum;
    logic [AW-1:0]                        tail;
    logic                                 full, empty, less, stop;

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
        slot_prev = (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
        slot_next = (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    sipq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ext    = {{VALUE_WIDTH{1'b0}}, s_data.value};
    assign in_val    = in_ext[VALUE_WIDTH-1:0];
    assign rd_ext    = {{VALUE_FIELD_W{1'b0}}, ram_rdata};
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // tail slot = (head + count) mod DEPTH, sum stays below 2*DEPTH
    assign tail_sum = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : tail_sum[AW-1:0];

    // read data is the entry just before idx; stop at the head or at a
    // neighbour that is not strictly smaller
    assign less = $signed(ram_rdata) < $signed(val_reg);
    assign stop = (idx_reg == head_reg) || !less;

    assign sts.in_deq     = (s_data.func == FUNC_DEQ);
    assign sts.full       = full;
    assign sts.empty      = empty;
    assign sts.shift_stop = stop;
    assign sts.out_free   = !out_valid_reg || m_ready;

    always_comb begin
        head_next        = head_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        val_next         = val_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = val_reg;
        ram_raddr        = head_reg;

        if (cmd.start) begin
            val_next        = in_val;
            pend_value_next = '0;
            if (s_data.func == FUNC_DEQ) begin
                pend_status_next = empty ? STATUS_EMPTY : STATUS_OK;
                ram_raddr        = head_reg;
            end else begin
                pend_status_next = full ? STATUS_FULL : STATUS_OK;
                if (empty) begin
                    head_next = '0;
                    idx_next  = '0;
                end else begin
                    idx_next = tail;
                end
                ram_raddr = slot_prev(idx_next);
            end
        end

        if (cmd.shift) begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg;
            if (stop) begin
                ram_wdata  = val_reg;
                count_next = count_reg + 1'b1;
            end else begin
                ram_wdata = ram_rdata;
                idx_next  = slot_prev(idx_reg);
                ram_raddr = slot_prev(slot_prev(idx_reg));
            end
        end

        if (cmd.dequeue) begin
            pend_value_next = rd_ext[VALUE_FIELD_W-1:0];
            count_next      = count_reg - 1'b1;
            head_next       = (count_reg == CW'(1)) ? '0 : slot_next(head_reg);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.publish) begin
            out_valid_next          = 1'b1;
            out_data_next.out_value = pend_value_reg;
            out_data_next.status    = pend_status_reg;
            out_data_next.count     = count_ext[COUNT_W-1:0];
            out_data_next.is_empty  = empty;
            out_data_next.is_full   = full;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        val_reg         <= val_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        out_data_reg    <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== src/sorted_insert_priority_queue_top.sv =====
// ---------------------------------------------------------------------------
// sorted_insert_priority_queue_top
// Bounded max-priority queue held sorted in a circular RAM.
// ---------------------------------------------------------------------------
// One operation is in flight at a time. An enqueue walks the new value from
// the tail towards the head one RAM slot per cycle, moving each strictly
// smaller entry back by one; the walk ends at the head or at the first entry
// that is not strictly smaller. A dequeue goes through accept, head read and
// result; a rejected operation goes from accept straight to the result. The
// result sits in an output register, so a new item is taken while a
// previous result still waits. Rejected operations (enqueue when full,
// dequeue when empty) report a status code and leave the queue unchanged.
module sorted_insert_priority_queue_top import sipq_pkg::*; #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sipq_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sipq_out_t m_data
);

    sipq_cmd_t cmd;
    sipq_sts_t sts;

    sipq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sipq_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== src/sipq_checker.sv =====
// ---------------------------------------------------------------------------
// sipq_checker
// Port-level checks on the priority queue, bound to the top level.
// ---------------------------------------------------------------------------
module sipq_checker import sipq_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input sipq_out_t m_data
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item at a time: an accepted item keeps the input closed next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |-> m_data.count == '0 && !m_data.is_full)
        else $error("empty flag disagrees with count");

    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_EMPTY
            |-> m_data.out_value == '0 && m_data.is_empty)
        else $error("empty reject with data or entries");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_FULL |-> m_data.is_full)
        else $error("full reject while not full");

endmodule

bind sorted_insert_priority_queue_top sipq_checker u_sipq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/tb_sorted_insert_priority_queue_top.sv =====
// ---------------------------------------------------------------------------
// tb_sorted_insert_priority_queue_top
// Self-checking bench for the sorted-insert priority queue. Each accepted
// operation is run through a behavioural max-priority queue, and each result
// transfer is checked field by field against the oldest prediction. Stimulus
// is a short directed set (value extremes, empty dequeue), fill/overflow
// rounds that wrap the circular store, an output hold-off that backs the
// block up, and biased random traffic, with random gaps on both channels.
// ---------------------------------------------------------------------------
module tb_sorted_insert_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sipq_pkg::*;

    localparam int QDEPTH         = 16;
    localparam int GAP_MAX        = 17;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * QDEPTH + 8;
    localparam logic signed [VALUE_FIELD_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_FIELD_W-1:0] VALUE_MIN = 32'sh8000_0000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sipq_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sipq_out_t m_data;

    // behavioural copy of the queue
    logic signed [VALUE_FIELD_W-1:0] pq_store [QDEPTH];
    int pq_head  = 0;
    int pq_count = 0;

    sipq_out_t expected_results [$];
    int  mismatches   = 0;
    int  idle_cycles  = 0;
    int  tx_gap_max   = GAP_MAX;
    int  rx_gap_max   = GAP_MAX;
    bit  hold_off_req = 1'b0;

    sorted_insert_priority_queue_top #(
        .DEPTH       (QDEPTH),
        .VALUE_WIDTH (VALUE_FIELD_W)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic sipq_out_t predict_pq(sipq_in_t item);
        sipq_out_t                       res;
        int                              slot;
        int                              prev;
        bit                              moving;
        logic signed [VALUE_FIELD_W-1:0] tmp;
        res = '0;
        res.status = STATUS_OK;
        if (item.func == FUNC_ENQ) begin
            if (pq_count == QDEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                if (pq_count == 0) begin
                    pq_head = 0;
                end
                slot = (pq_head + pq_count) % QDEPTH;
                pq_store[slot] = item.value;
                // bubble past strictly smaller entries only: ties keep arrival order
                moving = 1'b1;
                while (moving && slot != pq_head) begin
                    prev = (slot + QDEPTH - 1) % QDEPTH;
                    if (pq_store[prev] < pq_store[slot]) begin
                        tmp = pq_store[prev];
                        pq_store[prev] = pq_store[slot];
                        pq_store[slot] = tmp;
                        slot = prev;
                    end else begin
                        moving = 1'b0;
                    end
                end
                pq_count++;
            end
        end else if (pq_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.out_value = pq_store[pq_head];
            pq_count--;
            pq_head = (pq_count == 0) ? 0 : (pq_head + 1) % QDEPTH;
        end
        res.count    = COUNT_W'(pq_count);
        res.is_empty = (pq_count == 0);
        res.is_full  = (pq_count == QDEPTH);
        return res;
    endfunction

    function automatic logic signed [VALUE_FIELD_W-1:0] draw_value();
        logic signed [VALUE_FIELD_W-1:0] v;
        case ($urandom_range(0, 3))
            0: begin
                // narrow range, plenty of ties
                v = $urandom_range(0, 8) - 4;
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: v = VALUE_MAX;
                    1: v = VALUE_MIN;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: begin
                v = $urandom();
            end
        endcase
        return v;
    endfunction

    // valid is left high after the transfer; the next call lowers it only for a gap, stop_input lowers it
    task automatic send_item(input logic func, input logic signed [VALUE_FIELD_W-1:0] value);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{func: func, value: value};
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_pq('{func: func, value: value}));
    endtask

    task automatic stop_input();
        s_valid <= 1'b0;
    endtask

    task automatic set_idle_mode(input int mode);
        tx_gap_max = (mode == 1 || mode == 3) ? 0 : GAP_MAX;
        rx_gap_max = (mode == 2 || mode == 3) ? 0 : GAP_MAX;
    endtask

    task automatic test_empty_dequeue();
        send_item(FUNC_DEQ, VALUE_MAX);
    endtask

    task automatic test_value_extremes();
        send_item(FUNC_ENQ, '0);
        send_item(FUNC_ENQ, VALUE_MAX);
        send_item(FUNC_ENQ, VALUE_MIN);
        send_item(FUNC_ENQ, '1);
        send_item(FUNC_ENQ, 32'sd1);
        send_item(FUNC_ENQ, VALUE_MAX);
        send_item(FUNC_ENQ, VALUE_MIN);
        // seven entries out, then one dequeue on the empty queue
        repeat (8) send_item(FUNC_DEQ, $urandom());
    endtask

    task automatic test_fill_and_overflow();
        for (int round = 0; round < 4; round++) begin
            set_idle_mode(round);
            while (pq_count > 0) send_item(FUNC_DEQ, $urandom());
            // last one is turned away as full
            repeat (QDEPTH + 1) send_item(FUNC_ENQ, draw_value());
            // walk the head halfway round the store while staying near full
            repeat (8) begin
                send_item(FUNC_DEQ, $urandom());
                send_item(FUNC_ENQ, draw_value());
            end
            repeat (QDEPTH + 1) send_item(FUNC_DEQ, $urandom());
        end
        set_idle_mode(0);
    endtask

    task automatic test_backpressure();
        stop_input();
        wait (expected_results.size() == 0);
        tx_gap_max   = 0;
        hold_off_req = 1'b1;
        repeat (24) begin
            send_item(($urandom_range(0, 99) < 70) ? FUNC_ENQ : FUNC_DEQ, draw_value());
        end
        tx_gap_max = GAP_MAX;
    endtask

    task automatic test_random_traffic();
        int enq_pct;
        for (int blk = 0; blk < 20; blk++) begin
            set_idle_mode($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: enq_pct = 30;
                1: enq_pct = 50;
                2: enq_pct = 70;
                default: enq_pct = 85;
            endcase
            repeat (53) begin
                send_item(($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                          draw_value());
            end
        end
        set_idle_mode(0);
    endtask

    // result side: random stall per transfer, one long hold on request
    always begin : result_sink
        int stall;
        if (hold_off_req) begin
            stall        = LONG_HOLD;
            hold_off_req = 1'b0;
        end else begin
            stall = $urandom_range(0, rx_gap_max);
        end
        if (stall > 0) begin
            m_ready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (!m_valid);
    end

    always @(posedge aclk) begin : result_check
        sipq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no prediction pending: %p", m_data);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.out_value !== want.out_value) begin
                    $error("out_value: expected %0d, got %0d", want.out_value, m_data.out_value);
                    mismatches++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_data.count);
                    mismatches++;
                end
                if (m_data.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0b, got %0b", want.is_empty, m_data.is_empty);
                    mismatches++;
                end
                if (m_data.is_full !== want.is_full) begin
                    $error("is_full: expected %0b, got %0b", want.is_full, m_data.is_full);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_dequeue();
        test_value_extremes();
        test_fill_and_overflow();
        test_backpressure();
        test_random_traffic();
        stop_input();
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sipq_pkg.sv
src/sipq_ram.sv
src/sipq_ctrl.sv
src/sipq_dp.sv
src/sorted_insert_priority_queue_top.sv
src/sipq_checker.sv
dv/tb_sorted_insert_priority_queue_top.sv
